// ----- sv/gssa_pkg.sv -----
// ----------------------------------------------------------------------------
// gssa_pkg
// Shared widths, operation codes and register indexes of the stereo grain
// span accumulator.
// ----------------------------------------------------------------------------
package gssa_pkg;

   localparam int TAP_W       = 12;
   localparam int ENV_TAP_W   = 10;
   localparam int FRAC_W      = 16;
   localparam int SAMPLE_W    = 16;
   localparam int PAN_W       = 16;
   localparam int SPAN_W      = 13;
   localparam int BUS_W       = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [PAN_W-1:0]  PAN_RESET  = 16'd23170;
   localparam logic [SPAN_W-1:0] SPAN_RESET = 13'd4096;

   // interpolation lanes
   localparam int NUM_LANES  = 3;
   localparam int LANE_ENV   = 0;
   localparam int LANE_LEFT  = 1;
   localparam int LANE_RIGHT = 2;

   typedef enum logic [1:0] {
      OP_ACCUMULATE     = 2'd0,
      OP_WRITE_LEFT     = 2'd1,
      OP_WRITE_RIGHT    = 2'd2,
      OP_WRITE_ENVELOPE = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PAN_LEFT    = 2'd0,
      CSR_PAN_RIGHT   = 2'd1,
      CSR_SPAN_LENGTH = 2'd2
   } csr_index_type;

endpackage

// ----- sv/gssa_ifs.sv -----
// ----------------------------------------------------------------------------
// gssa channel interfaces
// Request, response and register-write channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface gssa_req_if import gssa_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [1:0]                 op;
   logic [TAP_W-1:0]           left_tap_a_or_write_addr;
   logic [TAP_W-1:0]           left_tap_b;
   logic [FRAC_W-1:0]          left_fraction;
   logic [TAP_W-1:0]           right_tap_a;
   logic [TAP_W-1:0]           right_tap_b;
   logic [FRAC_W-1:0]          right_fraction;
   logic [ENV_TAP_W-1:0]       envelope_tap_a;
   logic [ENV_TAP_W-1:0]       envelope_tap_b;
   logic [FRAC_W-1:0]          envelope_fraction;
   logic signed [BUS_W-1:0]    bus_left_or_write_value;
   logic signed [BUS_W-1:0]    bus_right_in;

   modport source (
      output valid, op, left_tap_a_or_write_addr, left_tap_b, left_fraction,
             right_tap_a, right_tap_b, right_fraction, envelope_tap_a,
             envelope_tap_b, envelope_fraction, bus_left_or_write_value,
             bus_right_in,
      input  ready
   );
   modport sink (
      input  valid, op, left_tap_a_or_write_addr, left_tap_b, left_fraction,
             right_tap_a, right_tap_b, right_fraction, envelope_tap_a,
             envelope_tap_b, envelope_fraction, bus_left_or_write_value,
             bus_right_in,
      output ready
   );
endinterface

interface gssa_rsp_if import gssa_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [BUS_W-1:0] bus_left_out;
   logic signed [BUS_W-1:0] bus_right_out;
   logic                    last_of_span;

   modport source (
      output valid, bus_left_out, bus_right_out, last_of_span,
      input  ready
   );
   modport sink (
      input  valid, bus_left_out, bus_right_out, last_of_span,
      output ready
   );
endinterface

interface gssa_csr_if import gssa_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/grain_span_stereo_accumulator_unit.sv -----
// ----------------------------------------------------------------------------
// grain_span_stereo_accumulator_unit
// Stereo grain mixer: interpolated ring taps times interpolated envelope
// times pan, added to the incoming bus with saturation.
// ----------------------------------------------------------------------------
// usage
//   req_chan carries one transaction per item. op selects accumulate or a
//   write of the left ring, right ring or envelope table; writes give no
//   response. Each accumulate gives one rsp_chan transaction with both
//   updated bus values and the last_of_span flag.
//   csr_chan writes pan_left, pan_right and span_length; it is always ready.
//   The user must write it only while the pipeline is empty; the block
//   itself does not enforce this. Accumulates pass through nine register
//   stages (quotient estimate, address wrap, memory read, lerp difference,
//   lerp product, lerp round, gain product, mix product, round and saturate).
//   Throughput: one transaction per cycle unless rsp_chan stalls a full
//   pipeline; every ring and the envelope table has one write and two reads.
//   Reset clears all stage valid bits and the span position and loads the
//   register defaults; ring and envelope contents stay undefined until
//   written, there is no clearing pass.
//   When rsp_chan stalls the stages hold; bubbles keep closing up, and
//   req_chan ready falls only once all nine stages are full.
// ----------------------------------------------------------------------------
module grain_span_stereo_accumulator_unit import gssa_pkg::*; #(
   parameter int RING_DEPTH     = 4096,
   parameter int ENVELOPE_DEPTH = 1024,
   parameter int MAX_SPAN       = 4096
) (
   input  logic        clock,
   input  logic        reset,
   gssa_req_if.sink    req_chan,
   gssa_rsp_if.source  rsp_chan,
   gssa_csr_if.sink    csr_chan
);

   localparam int NUM_STAGES = 9;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int ENV_AW     = $clog2(ENVELOPE_DEPTH);

   // address wrap by reciprocal multiply, exact for TAP_W bit addresses
   localparam int MUL_W      = TAP_W + 2;
   localparam int PRODQ_W    = TAP_W + MUL_W;
   localparam bit RING_WRAP  = RING_DEPTH < (1 << TAP_W);
   localparam bit ENV_WRAP   = ENVELOPE_DEPTH < (1 << TAP_W);
   localparam int RING_SH    = TAP_W + RING_AW;
   localparam int ENV_SH     = TAP_W + ENV_AW;
   localparam int RING_MUL   = RING_WRAP ?
                               (((1 << RING_SH) + RING_DEPTH - 1) / RING_DEPTH) : 0;
   localparam int ENV_MUL    = ENV_WRAP ?
                               (((1 << ENV_SH) + ENVELOPE_DEPTH - 1) / ENVELOPE_DEPTH) : 0;
   localparam logic [TAP_W-1:0] RING_DIV = RING_WRAP ? TAP_W'(RING_DEPTH) : '0;
   localparam logic [TAP_W-1:0] ENV_DIV  = ENV_WRAP ? TAP_W'(ENVELOPE_DEPTH) : '0;

   localparam int NUM_ADDR   = 7;
   localparam int NUM_RADDR  = 4;
   localparam int AX_LA      = 0;
   localparam int AX_LB      = 1;
   localparam int AX_RA      = 2;
   localparam int AX_RB      = 3;
   localparam int AX_EA      = 4;
   localparam int AX_EB      = 5;
   localparam int AX_EW      = 6;

   localparam int POS_W      = $clog2(MAX_SPAN + 1);
   localparam int CMP_W      = (POS_W > SPAN_W) ? POS_W : SPAN_W;

   localparam int DIFF_W     = SAMPLE_W + 1;
   localparam int LPROD_W    = FRAC_W + DIFF_W + 1;
   localparam int GAIN_W     = SAMPLE_W + PAN_W + 1;
   localparam int MIX_W      = GAIN_W + SAMPLE_W;
   localparam int MIX_SH     = 2 * SAMPLE_W - 2;
   localparam int SAMPLE_MAX = (1 << (SAMPLE_W - 1)) - 1;
   localparam int SAMPLE_MIN = -(1 << (SAMPLE_W - 1));
   localparam int CH_LEFT    = 0;
   localparam int CH_RIGHT   = 1;

   localparam logic signed [LPROD_W-1:0] LERP_HALF = LPROD_W'(1 << (FRAC_W - 1));
   localparam logic signed [MIX_W-1:0]   MIX_HALF  = MIX_W'(longint'(1) << (MIX_SH - 1));
   localparam logic signed [BUS_W:0]     BUS_MAX   =
      (BUS_W+1)'((longint'(1) << (BUS_W - 1)) - 1);
   localparam logic signed [BUS_W:0]     BUS_MIN   =
      (BUS_W+1)'(-(longint'(1) << (BUS_W - 1)));

   typedef struct packed {
      logic signed [BUS_W-1:0] bus_left;
      logic signed [BUS_W-1:0] bus_right;
      logic                    last;
   } side_type;

   function automatic logic [TAP_W-1:0] wrap_quot(input logic [TAP_W-1:0] x,
                                                  input logic [MUL_W-1:0] mul,
                                                  input int sh);
      logic [PRODQ_W-1:0] p;
      p = PRODQ_W'(x) * PRODQ_W'(mul);
      return TAP_W'(p >> sh);
   endfunction

   function automatic logic [TAP_W-1:0] wrap_rem(input logic [TAP_W-1:0] x,
                                                 input logic [TAP_W-1:0] q,
                                                 input logic [TAP_W-1:0] div);
      logic [TAP_W-1:0] qd;
      qd = TAP_W'(q * div);
      return x - qd;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [BUS_W-1:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > BUS_W'(SAMPLE_MAX)) begin
         r = SAMPLE_W'(SAMPLE_MAX);
      end else if (v < BUS_W'(SAMPLE_MIN)) begin
         r = SAMPLE_W'(SAMPLE_MIN);
      end else begin
         r = SAMPLE_W'(v);
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   logic [PAN_W-1:0]  pan_left_ff;
   logic [PAN_W-1:0]  pan_right_ff;
   logic [SPAN_W-1:0] span_length_ff;
   logic [POS_W-1:0]  span_pos_ff;
   logic [POS_W-1:0]  span_pos_in;

   logic [NUM_STAGES:1]   v_ff;
   logic [NUM_STAGES+1:1] adv;
   logic [NUM_STAGES:1]   load;

   side_type side_ff [1:NUM_STAGES-1];

   // stage 1: quotient estimates
   logic [1:0]                 op1_ff;
   logic signed [SAMPLE_W-1:0] wval1_ff;
   logic [FRAC_W-1:0]          frac1_ff [NUM_LANES];
   logic [TAP_W-1:0]           x1_ff [NUM_ADDR];
   logic [TAP_W-1:0]           q1_ff [NUM_ADDR];
   logic [TAP_W-1:0]           x_in  [NUM_ADDR];
   logic [TAP_W-1:0]           q_in  [NUM_ADDR];

   // stage 2: wrapped addresses
   logic [1:0]                 op2_ff;
   logic signed [SAMPLE_W-1:0] wval2_ff;
   logic [FRAC_W-1:0]          frac2_ff [NUM_LANES];
   logic [RING_AW-1:0]         ring_addr2_ff [NUM_RADDR];
   logic [ENV_AW-1:0]          env_addr2_ff  [NUM_ADDR-NUM_RADDR];
   logic [TAP_W-1:0]           rem_in [NUM_ADDR];

   // stage 3: memory read data
   logic signed [SAMPLE_W-1:0] left_mem  [RING_DEPTH];
   logic signed [SAMPLE_W-1:0] right_mem [RING_DEPTH];
   logic signed [SAMPLE_W-1:0] env_mem   [ENVELOPE_DEPTH];
   logic signed [SAMPLE_W-1:0] left_rd_ff  [2];
   logic signed [SAMPLE_W-1:0] right_rd_ff [2];
   logic signed [SAMPLE_W-1:0] env_rd_ff   [2];
   logic [FRAC_W-1:0]          frac3_ff [NUM_LANES];
   logic signed [SAMPLE_W-1:0] tap_a3 [NUM_LANES];
   logic signed [SAMPLE_W-1:0] tap_b3 [NUM_LANES];
   logic                       wr_left;
   logic                       wr_right;
   logic                       wr_env;

   // stages 4 to 6: interpolation
   logic signed [DIFF_W-1:0]   diff4_ff [NUM_LANES];
   logic signed [SAMPLE_W-1:0] a4_ff    [NUM_LANES];
   logic [FRAC_W-1:0]          frac4_ff [NUM_LANES];
   logic signed [LPROD_W-1:0]  lprod5_ff [NUM_LANES];
   logic signed [SAMPLE_W-1:0] a5_ff     [NUM_LANES];
   logic signed [SAMPLE_W-1:0] interp6_ff [NUM_LANES];
   logic signed [SAMPLE_W-1:0] interp_in  [NUM_LANES];

   // stages 7 to 9: gain, mix, bus update
   logic signed [GAIN_W-1:0]   gain7_ff [2];
   logic signed [SAMPLE_W-1:0] samp7_ff [2];
   logic signed [MIX_W-1:0]    mix8_ff  [2];
   logic signed [BUS_W-1:0]    out9_ff  [2];
   logic signed [BUS_W-1:0]    out_in   [2];
   logic                       last9_ff;

   // span counter
   logic [CMP_W-1:0] span_len_eff;
   logic [CMP_W-1:0] pos_next;
   logic             acc_last;
   logic             req_acc;
   logic             req_is_acc;

   // ------------------------------------------------------------------------
   // handshake: each stage loads when it is empty or its content moves on
   // ------------------------------------------------------------------------
   always_comb begin
      adv[NUM_STAGES+1] = rsp_chan.ready;
      for (int k = NUM_STAGES; k >= 1; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
      load[1] = adv[1] && req_chan.valid;
      for (int k = 2; k <= NUM_STAGES; k++) begin
         load[k] = adv[k] && v_ff[k-1];
      end
   end

   assign req_chan.ready = adv[1];
   assign req_acc        = req_chan.valid && adv[1];
   assign req_is_acc     = req_chan.op == OP_ACCUMULATE;

   assign rsp_chan.valid         = v_ff[NUM_STAGES];
   assign rsp_chan.bus_left_out  = out9_ff[CH_LEFT];
   assign rsp_chan.bus_right_out = out9_ff[CH_RIGHT];
   assign rsp_chan.last_of_span  = last9_ff;

   assign csr_chan.ready = 1'b1;

   // ------------------------------------------------------------------------
   // span position
   // ------------------------------------------------------------------------
   always_comb begin
      span_len_eff = CMP_W'(span_length_ff);
      if (span_len_eff == '0) begin
         span_len_eff = CMP_W'(1);
      end else if (span_len_eff > CMP_W'(MAX_SPAN)) begin
         span_len_eff = CMP_W'(MAX_SPAN);
      end
      pos_next    = CMP_W'(span_pos_ff) + CMP_W'(1);
      acc_last    = pos_next >= span_len_eff;
      span_pos_in = span_pos_ff;
      if (req_acc && req_is_acc) begin
         span_pos_in = acc_last ? '0 : POS_W'(pos_next);
      end
   end

   // ------------------------------------------------------------------------
   // control registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff           <= '0;
         span_pos_ff    <= '0;
         pan_left_ff    <= PAN_RESET;
         pan_right_ff   <= PAN_RESET;
         span_length_ff <= SPAN_RESET;
      end else begin
         span_pos_ff <= span_pos_in;
         if (adv[1]) begin
            v_ff[1] <= req_chan.valid;
         end
         if (adv[2]) begin
            v_ff[2] <= v_ff[1];
         end
         // write transactions end at the memories
         if (adv[3]) begin
            v_ff[3] <= v_ff[2] && (op2_ff == OP_ACCUMULATE);
         end
         for (int k = 4; k <= NUM_STAGES; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
         if (csr_chan.valid) begin
            unique case (csr_index_type'(csr_chan.index))
               CSR_PAN_LEFT:    pan_left_ff    <= csr_chan.data;
               CSR_PAN_RIGHT:   pan_right_ff   <= csr_chan.data;
               CSR_SPAN_LENGTH: span_length_ff <= SPAN_W'(csr_chan.data);
               default: ;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // address wrap
   // ------------------------------------------------------------------------
   always_comb begin
      x_in[AX_LA] = req_chan.left_tap_a_or_write_addr;
      x_in[AX_LB] = req_chan.left_tap_b;
      x_in[AX_RA] = req_chan.right_tap_a;
      x_in[AX_RB] = req_chan.right_tap_b;
      x_in[AX_EA] = TAP_W'(req_chan.envelope_tap_a);
      x_in[AX_EB] = TAP_W'(req_chan.envelope_tap_b);
      x_in[AX_EW] = req_chan.left_tap_a_or_write_addr;
      for (int i = 0; i < NUM_ADDR; i++) begin
         if (i < NUM_RADDR) begin
            q_in[i] = wrap_quot(x_in[i], MUL_W'(RING_MUL), RING_SH);
         end else begin
            q_in[i] = wrap_quot(x_in[i], MUL_W'(ENV_MUL), ENV_SH);
         end
      end
      for (int i = 0; i < NUM_ADDR; i++) begin
         if (i < NUM_RADDR) begin
            rem_in[i] = wrap_rem(x1_ff[i], q1_ff[i], RING_DIV);
         end else begin
            rem_in[i] = wrap_rem(x1_ff[i], q1_ff[i], ENV_DIV);
         end
      end
   end

   // ------------------------------------------------------------------------
   // memories: one write and two reads each
   // ------------------------------------------------------------------------
   assign wr_left  = load[3] && (op2_ff == OP_WRITE_LEFT);
   assign wr_right = load[3] && (op2_ff == OP_WRITE_RIGHT);
   assign wr_env   = load[3] && (op2_ff == OP_WRITE_ENVELOPE);

   always_ff @(posedge clock) begin
      if (wr_left) begin
         left_mem[ring_addr2_ff[AX_LA]] <= wval2_ff;
      end
      if (load[3]) begin
         left_rd_ff[0] <= left_mem[ring_addr2_ff[AX_LA]];
         left_rd_ff[1] <= left_mem[ring_addr2_ff[AX_LB]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_right) begin
         right_mem[ring_addr2_ff[AX_LA]] <= wval2_ff;
      end
      if (load[3]) begin
         right_rd_ff[0] <= right_mem[ring_addr2_ff[AX_RA]];
         right_rd_ff[1] <= right_mem[ring_addr2_ff[AX_RB]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_env) begin
         env_mem[env_addr2_ff[AX_EW-NUM_RADDR]] <= wval2_ff;
      end
      if (load[3]) begin
         env_rd_ff[0] <= env_mem[env_addr2_ff[AX_EA-NUM_RADDR]];
         env_rd_ff[1] <= env_mem[env_addr2_ff[AX_EB-NUM_RADDR]];
      end
   end

   always_comb begin
      tap_a3[LANE_ENV]   = env_rd_ff[0];
      tap_b3[LANE_ENV]   = env_rd_ff[1];
      tap_a3[LANE_LEFT]  = left_rd_ff[0];
      tap_b3[LANE_LEFT]  = left_rd_ff[1];
      tap_a3[LANE_RIGHT] = right_rd_ff[0];
      tap_b3[LANE_RIGHT] = right_rd_ff[1];
   end

   // ------------------------------------------------------------------------
   // arithmetic
   // ------------------------------------------------------------------------
   always_comb begin
      logic signed [LPROD_W-1:0] t;
      logic signed [MIX_W-1:0]   contrib;
      logic signed [BUS_W:0]     sum;
      logic signed [BUS_W-1:0]   bus;
      for (int l = 0; l < NUM_LANES; l++) begin
         // a + round(f * (b - a) / 2^16), rounding half up
         t            = (lprod5_ff[l] + LERP_HALF) >>> FRAC_W;
         interp_in[l] = SAMPLE_W'(t + LPROD_W'(a5_ff[l]));
      end
      for (int c = 0; c < 2; c++) begin
         bus     = (c == CH_LEFT) ? side_ff[NUM_STAGES-1].bus_left
                                  : side_ff[NUM_STAGES-1].bus_right;
         contrib = (mix8_ff[c] + MIX_HALF) >>> MIX_SH;
         sum     = (BUS_W+1)'(bus) + (BUS_W+1)'(contrib);
         if (sum > BUS_MAX) begin
            out_in[c] = BUS_W'(BUS_MAX);
         end else if (sum < BUS_MIN) begin
            out_in[c] = BUS_W'(BUS_MIN);
         end else begin
            out_in[c] = BUS_W'(sum);
         end
      end
   end

   // ------------------------------------------------------------------------
   // payload registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (load[1]) begin
         op1_ff                <= req_chan.op;
         wval1_ff              <= sat_sample(req_chan.bus_left_or_write_value);
         frac1_ff[LANE_ENV]    <= req_chan.envelope_fraction;
         frac1_ff[LANE_LEFT]   <= req_chan.left_fraction;
         frac1_ff[LANE_RIGHT]  <= req_chan.right_fraction;
         x1_ff                 <= x_in;
         q1_ff                 <= q_in;
         side_ff[1].bus_left   <= req_chan.bus_left_or_write_value;
         side_ff[1].bus_right  <= req_chan.bus_right_in;
         side_ff[1].last       <= acc_last;
      end
      for (int k = 2; k <= NUM_STAGES - 1; k++) begin
         if (load[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
      if (load[2]) begin
         op2_ff   <= op1_ff;
         wval2_ff <= wval1_ff;
         frac2_ff <= frac1_ff;
         for (int i = 0; i < NUM_RADDR; i++) begin
            ring_addr2_ff[i] <= RING_AW'(rem_in[i]);
         end
         for (int i = NUM_RADDR; i < NUM_ADDR; i++) begin
            env_addr2_ff[i-NUM_RADDR] <= ENV_AW'(rem_in[i]);
         end
      end
      if (load[3]) begin
         frac3_ff <= frac2_ff;
      end
      if (load[4]) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            diff4_ff[l] <= DIFF_W'(tap_b3[l]) - DIFF_W'(tap_a3[l]);
            a4_ff[l]    <= tap_a3[l];
         end
         frac4_ff <= frac3_ff;
      end
      if (load[5]) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            lprod5_ff[l] <= $signed({1'b0, frac4_ff[l]}) * diff4_ff[l];
         end
         a5_ff <= a4_ff;
      end
      if (load[6]) begin
         interp6_ff <= interp_in;
      end
      if (load[7]) begin
         gain7_ff[CH_LEFT]  <= interp6_ff[LANE_ENV] * $signed({1'b0, pan_left_ff});
         gain7_ff[CH_RIGHT] <= interp6_ff[LANE_ENV] * $signed({1'b0, pan_right_ff});
         samp7_ff[CH_LEFT]  <= interp6_ff[LANE_LEFT];
         samp7_ff[CH_RIGHT] <= interp6_ff[LANE_RIGHT];
      end
      if (load[8]) begin
         for (int c = 0; c < 2; c++) begin
            mix8_ff[c] <= gain7_ff[c] * samp7_ff[c];
         end
      end
      if (load[9]) begin
         out9_ff  <= out_in;
         last9_ff <= side_ff[NUM_STAGES-1].last;
      end
   end

`ifndef SYNTHESIS
   // the final item of a span sends the position back to zero
   assert property (@(posedge clock) disable iff (reset)
      req_acc && req_is_acc && acc_last |=> span_pos_ff == '0)
      else $error("span position not cleared after last item");

   // input stalls only when every stage is full and the output is held
   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (&v_ff) && !rsp_chan.ready)
      else $error("input stalled with a bubble in the pipeline");

   // a blocked item in the mix stage is kept
   assert property (@(posedge clock) disable iff (reset)
      v_ff[NUM_STAGES-1] && !adv[NUM_STAGES] |=> v_ff[NUM_STAGES-1])
      else $error("mix stage item lost while stalled");
`endif

endmodule
